[design/jsi_pkg.sv]
package jsi_pkg;

  // text chunk geometry
  localparam int CHUNK_W     = 64;
  localparam int CHUNK_MSB   = 63;
  localparam int BYTE_W      = 8;
  localparam int CHUNK_LANES = CHUNK_W / BYTE_W;

  // result geometry
  localparam int TOKEN_W = 32;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // character codes
  localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_COMMA     = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_COLON     = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_LBRACKET  = 8'h5B;
  localparam logic [BYTE_W-1:0] CHAR_RBRACKET  = 8'h5D;
  localparam logic [BYTE_W-1:0] CHAR_LBRACE    = 8'h7B;
  localparam logic [BYTE_W-1:0] CHAR_RBRACE    = 8'h7D;
  localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    CLS_BACKSLASH,
    CLS_QUOTE,
    CLS_STRUCT,
    CLS_SPACE,
    CLS_OTHER
  } byte_class_t;

  // byte classifier
  function automatic byte_class_t classify(input logic [BYTE_W-1:0] c);
    byte_class_t cls;
    case (c)
      CHAR_BACKSLASH: cls = CLS_BACKSLASH;
      CHAR_QUOTE:     cls = CLS_QUOTE;
      CHAR_COMMA, CHAR_COLON, CHAR_LBRACKET, CHAR_RBRACKET,
      CHAR_LBRACE, CHAR_RBRACE: cls = CLS_STRUCT;
      CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_SPACE: cls = CLS_SPACE;
      default:        cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

[design/jsi_if.sv]
interface jsi_in_if;
  logic                         valid;
  logic                         ready;
  logic [jsi_pkg::CHUNK_MSB:0]  chunk_bytes;
  logic [3:0]                   byte_count;
  logic                         end_of_input;

  modport source (output valid, output chunk_bytes, output byte_count,
                  output end_of_input, input ready);
  modport sink   (input valid, input chunk_bytes, input byte_count,
                  input end_of_input, output ready);
endinterface

interface jsi_out_if;
  logic                          valid;
  logic                          ready;
  logic [jsi_pkg::TOKEN_W-1:0]   token_position;
  logic                          end_marker;
  logic                          last;

  modport source (output valid, output token_position, output end_marker,
                  output last, input ready);
  modport sink   (input valid, input token_position, input end_marker,
                  input last, output ready);
endinterface

[design/jsi_front.sv]
module jsi_front #(
  parameter int LANES = 8,
  parameter int POS_W = 32,
  localparam int NL = (LANES < jsi_pkg::CHUNK_LANES) ? LANES : jsi_pkg::CHUNK_LANES
) (
  input  logic             clk,
  input  logic             rst,
  jsi_in_if.sink           chunks,
  input  logic             q_full,
  output logic             q_push,
  output logic [NL-1:0]    tok_mask,
  output logic [POS_W-1:0] base_pos,
  output logic [POS_W-1:0] end_pos,
  output logic             end_flag
);

  localparam int CNT_W = $clog2(LANES + 1);

  logic             escape_pending;
  logic             inside_string;
  logic             previous_separator;
  logic [POS_W-1:0] byte_position;

  logic             escape_next;
  logic             inside_next;
  logic             separator_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  // saturate byte count to the lane count
  always_comb begin
    if (7'(chunks.byte_count) > 7'(LANES)) begin
      cnt = CNT_W'(LANES);
    end else begin
      cnt = CNT_W'(chunks.byte_count);
    end
  end

  // lane scan: escapes, string state and token starts
  always_comb begin
    logic                          esc;
    logic                          ins;
    logic                          psep;
    logic [jsi_pkg::BYTE_W-1:0]    c;
    jsi_pkg::byte_class_t          cls;
    logic                          q;
    logic                          ws;
    logic                          st;
    esc  = escape_pending;
    ins  = inside_string;
    psep = previous_separator;
    tok_mask = '0;
    for (int i = 0; i < NL; i++) begin
      if (7'(i) < 7'(cnt)) begin
        c = chunks.chunk_bytes[jsi_pkg::BYTE_W*i +: jsi_pkg::BYTE_W];
      end else begin
        c = jsi_pkg::CHAR_SPACE;
      end
      cls = jsi_pkg::classify(c);
      q   = (cls == jsi_pkg::CLS_QUOTE) && !esc;
      esc = (cls == jsi_pkg::CLS_BACKSLASH) && !esc;
      ins = ins ^ q;
      ws  = (cls == jsi_pkg::CLS_SPACE);
      st  = (cls == jsi_pkg::CLS_STRUCT);
      tok_mask[i] = q | ((st | (psep & !ws)) & !ins);
      psep = ws | st;
    end
    // lanes above the chunk width are spaces
    if (LANES > jsi_pkg::CHUNK_LANES) begin
      esc  = 1'b0;
      psep = 1'b1;
    end
    escape_next    = esc;
    inside_next    = ins;
    separator_next = psep;
  end

  assign chunks.ready = !q_full;
  assign accept       = chunks.valid && !q_full;

  // queue entry: only items that cause results are queued
  assign base_pos = byte_position;
  assign end_pos  = byte_position + POS_W'(cnt);
  assign end_flag = chunks.end_of_input;
  assign q_push   = accept && ((|tok_mask) || chunks.end_of_input);

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending     <= 1'b0;
      inside_string      <= 1'b0;
      previous_separator <= 1'b1;
      byte_position      <= '0;
    end else if (accept) begin
      if (chunks.end_of_input) begin
        escape_pending     <= 1'b0;
        inside_string      <= 1'b0;
        previous_separator <= 1'b1;
        byte_position      <= '0;
      end else begin
        escape_pending     <= escape_next;
        inside_string      <= inside_next;
        previous_separator <= separator_next;
        byte_position      <= end_pos;
      end
    end
  end

endmodule

[design/jsi_queue.sv]
module jsi_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]               entries [jsi_pkg::QUEUE_DEPTH];
  logic [jsi_pkg::QPTR_W-1:0]     wr_ptr;
  logic [jsi_pkg::QPTR_W-1:0]     rd_ptr;
  logic [jsi_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == jsi_pkg::QCNT_W'(jsi_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

[design/jsi_back.sv]
module jsi_back #(
  parameter int LANES = 8,
  parameter int POS_W = 32,
  localparam int NL = (LANES < jsi_pkg::CHUNK_LANES) ? LANES : jsi_pkg::CHUNK_LANES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [NL-1:0]    head_mask,
  input  logic [POS_W-1:0] head_base,
  input  logic [POS_W-1:0] head_end_pos,
  input  logic             head_end,
  output logic             q_pop,
  jsi_out_if.source        tokens
);

  localparam int LW    = (NL > 1) ? $clog2(NL) : 1;
  localparam int EXT_W = (POS_W > jsi_pkg::TOKEN_W) ? POS_W : jsi_pkg::TOKEN_W;

  logic [NL-1:0]    done_mask;
  logic             out_valid;
  logic [NL-1:0]    remaining;
  logic [NL-1:0]    sel_onehot;
  logic [LW-1:0]    sel_lane;
  logic             has_tok;
  logic             more;
  logic             res_last;
  logic             advance;
  logic [POS_W-1:0] res_pos;
  logic [EXT_W-1:0] res_pos_ext;

  // lowest lane not yet sent
  always_comb begin
    remaining = head_mask & ~done_mask;
    sel_lane  = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel_lane = LW'(i);
      end
    end
    sel_onehot = NL'(1) << sel_lane;
    has_tok    = |remaining;
    more       = |(remaining & ~sel_onehot);
  end

  // result selection: token start, else end marker
  always_comb begin
    if (has_tok) begin
      res_pos  = head_base + POS_W'(sel_lane);
      res_last = !more && !head_end;
    end else begin
      res_pos  = head_end_pos;
      res_last = 1'b1;
    end
    res_pos_ext = EXT_W'(res_pos);
  end

  assign advance      = !q_empty && (!out_valid || tokens.ready);
  assign q_pop        = advance && res_last;
  assign tokens.valid = out_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done_mask <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        done_mask <= '0;
      end else if (advance) begin
        done_mask <= done_mask | sel_onehot;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      tokens.token_position <= res_pos_ext[jsi_pkg::TOKEN_W-1:0];
      tokens.end_marker     <= !has_tok;
      tokens.last           <= res_last;
    end
  end

endmodule

[design/json_structural_indexer.sv]
// JSON structural indexer, first tokenizer stage.
// chunks: text in chunks of up to eight bytes, first byte in bits 7:0, with a
//   byte count (padding lanes act as spaces) and an end-of-input flag.
// tokens: one item per token start, in ascending byte order: unescaped quotes,
//   structural characters outside strings, and scalar starts. The final chunk
//   adds an end marker carrying the total length; last flags the final item
//   caused by each chunk. Chunks that cause no token are absorbed silently.
// Throughput: one chunk per cycle in; one token per cycle out while the
//   receiver is ready. The front scans a chunk combinationally and pushes it
//   into a four-entry queue; the back drains one token per cycle, so only dense
//   chunks (more than one token each on average) slow input once it is full.
// Path: an accepted chunk is written into the queue, its tokens then pass
//   through the output register, one per cycle while the receiver is ready.
// Reset (rst, synchronous): queue and output register empty, scan state back
//   to document start. chunks.ready is high the cycle after reset.
// Receiver stall: the output register holds its item; the back stops, the
//   queue fills and chunks.ready drops when it is full.
module json_structural_indexer #(
  parameter int LANES = 8,
  parameter int POSITION_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  jsi_in_if.sink     chunks,
  jsi_out_if.source  tokens
);

  localparam int NL = (LANES < jsi_pkg::CHUNK_LANES) ? LANES : jsi_pkg::CHUNK_LANES;

  typedef struct packed {
    logic                      end_flag;
    logic [POSITION_WIDTH-1:0] end_pos;
    logic [POSITION_WIDTH-1:0] base_pos;
    logic [NL-1:0]             tok_mask;
  } entry_t;

  entry_t wr_entry;
  entry_t rd_entry;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  // classify and scan
  jsi_front #(
    .LANES (LANES),
    .POS_W (POSITION_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .chunks   (chunks),
    .q_full   (q_full),
    .q_push   (q_push),
    .tok_mask (wr_entry.tok_mask),
    .base_pos (wr_entry.base_pos),
    .end_pos  (wr_entry.end_pos),
    .end_flag (wr_entry.end_flag)
  );

  // chunk queue
  jsi_queue #(
    .WIDTH ($bits(entry_t))
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (wr_entry),
    .pop     (q_pop),
    .rd_data (rd_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  // token serializer
  jsi_back #(
    .LANES (LANES),
    .POS_W (POSITION_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head_mask    (rd_entry.tok_mask),
    .head_base    (rd_entry.base_pos),
    .head_end_pos (rd_entry.end_pos),
    .head_end     (rd_entry.end_flag),
    .q_pop        (q_pop),
    .tokens       (tokens)
  );

endmodule

[design/jsi_checker.sv]
module jsi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [jsi_pkg::TOKEN_W-1:0]   out_pos,
  input logic                          out_end_marker,
  input logic                          out_last
);

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pos)
      && $stable(out_end_marker) && $stable(out_last))
    else $error("stalled token item changed");

  // the end marker closes its chunk's results
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end_marker |-> out_last)
    else $error("end marker without last");

  // reset empties the output side
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token item valid after reset");

  // reset empties the queue, so input is taken again
  a_reset_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("chunk input not ready after reset");

endmodule

bind json_structural_indexer jsi_checker u_jsi_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (chunks.ready),
  .out_valid      (tokens.valid),
  .out_ready      (tokens.ready),
  .out_pos        (tokens.token_position),
  .out_end_marker (tokens.end_marker),
  .out_last       (tokens.last)
);
